FILE: hw/rtl/tmw_pkg.sv
// shared constants, types and controller states of the trimmed mean window filter
`default_nettype none

package tmw_pkg;

  // window geometry and field widths
  localparam int unsigned WINDOW      = 15;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned OUT_BITS    = 16;
  localparam int unsigned OMIT_BITS   = 3;

  // derived sizes
  localparam int unsigned MAX_TRIM  = (WINDOW - 1) / 2;
  localparam int unsigned RANK_BITS = $clog2(WINDOW);
  localparam int unsigned CNT_BITS  = $clog2(WINDOW + 1);
  localparam int unsigned SUM_BITS  = SAMPLE_BITS + RANK_BITS;
  localparam int unsigned STEP_BITS = $clog2(SUM_BITS);

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [OUT_BITS-1:0]    mean_t;
  typedef logic [OMIT_BITS-1:0]   omit_t;
  typedef logic [RANK_BITS-1:0]   rank_t;
  typedef logic [RANK_BITS:0]     col_t;
  typedef logic [CNT_BITS-1:0]    cnt_t;
  typedef logic [SUM_BITS-1:0]    sum_t;
  typedef logic [STEP_BITS-1:0]   step_t;

  localparam omit_t OMIT_RESET = omit_t'(4);
  localparam rank_t TRIM_LIMIT = rank_t'(MAX_TRIM);
  localparam step_t LAST_BIT   = step_t'(SAMPLE_BITS - 1);
  localparam step_t LAST_DIV   = step_t'(SUM_BITS - 1);

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMPARE,
    ST_RANK,
    ST_ACCUM,
    ST_DIVIDE
  } tmw_state_e;

endpackage

`default_nettype wire

FILE: hw/rtl/tmw_sample_if.sv
// valid/ready channel carrying one raw sample item
`default_nettype none

interface tmw_sample_if;
  import tmw_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/tmw_mean_if.sv
// valid/ready channel carrying one trimmed mean item
`default_nettype none

interface tmw_mean_if;
  import tmw_pkg::*;

  logic  valid;
  logic  ready;
  mean_t trimmed_mean;

  modport source (output valid, output trimmed_mean, input ready);
  modport sink   (input valid, input trimmed_mean, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/trimmed_mean_window_filter_top.sv
// Alpha-trimmed mean filter: a 15-sample sliding window, drops the omit_count
// smallest and largest values and outputs the truncated mean of the rest. The
// datapath is bit serial: the window rotates one bit per cycle, LSB first,
// through a pairwise comparison pass, a rank step that turns the comparison
// flags into ranks, a serial summing pass of the kept values and a restoring
// division by the kept count, one quotient bit per cycle, where the last bit
// waits while an earlier result is still unread on the output. The input
// reopens as the result is loaded into the output register, so no new sample
// is taken before the last one is through. The first sample after reset
// fills the whole window. omit_count is written through cfg_we_i/cfg_wdata_i;
// the user must write it only while the block is idle, as the block does not
// enforce this. It resets to 4 and is clamped to 7.
`default_nettype none

module trimmed_mean_window_filter_top (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  tmw_sample_if.sink                 in_if,
  tmw_mean_if.source                 out_if,
  input  wire logic                  cfg_we_i,
  input  wire tmw_pkg::omit_t        cfg_wdata_i
);
  import tmw_pkg::*;

  tmw_state_e state_q, state_d;

  logic  primed_q;
  omit_t omit_q;
  step_t step_q;

  sample_t              win_q [WINDOW];
  logic [WINDOW-1:0]    gt_q  [WINDOW];
  logic [WINDOW-1:0]    below_w [WINDOW];
  rank_t                rank_w  [WINDOW];
  logic [WINDOW-1:0]    keep_w, keep_q;
  logic [WINDOW-1:0]    lsb_w;

  sample_t sum_lo_q;
  rank_t   carry_q;
  col_t    col_w;
  sum_t    quo_q, quo_d;
  cnt_t    rem_q, rem_d;
  logic [CNT_BITS:0] trial_w;
  logic    quo_bit_w;

  rank_t trim_w;
  cnt_t  cnt_w;
  cnt_t  hi_w;

  mean_t out_mean_q;
  logic  out_valid_q;

  logic in_ready, accept;
  logic rotate, cmp_en, keep_en, acc_en, div_step, out_load;
  logic last_bit, last_div;

  assign accept   = in_if.valid & in_ready;
  assign last_bit = (step_q == LAST_BIT);
  assign last_div = (step_q == LAST_DIV);

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      omit_q <= OMIT_RESET;
    end else if (cfg_we_i) begin
      omit_q <= cfg_wdata_i;
    end
  end

  // trim count clamp and number of kept values
  always_comb begin
    trim_w = (rank_t'(omit_q) > TRIM_LIMIT) ? TRIM_LIMIT : rank_t'(omit_q);
    cnt_w  = cnt_t'(WINDOW) - cnt_t'({trim_w, 1'b0});
    hi_w   = cnt_t'(WINDOW) - cnt_t'(trim_w);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (accept)   state_d = ST_COMPARE;
      ST_COMPARE: if (last_bit) state_d = ST_RANK;
      ST_RANK:                  state_d = ST_ACCUM;
      ST_ACCUM:   if (last_bit) state_d = ST_DIVIDE;
      ST_DIVIDE:  if (out_load) state_d = ST_IDLE;
      default:                  state_d = ST_IDLE;
    endcase
  end

  // controller outputs
  always_comb begin
    in_ready = 1'b0;
    rotate   = 1'b0;
    cmp_en   = 1'b0;
    keep_en  = 1'b0;
    acc_en   = 1'b0;
    div_step = 1'b0;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_COMPARE: begin
        cmp_en = 1'b1;
        rotate = 1'b1;
      end
      ST_RANK: begin
        keep_en = 1'b1;
      end
      ST_ACCUM: begin
        acc_en = 1'b1;
        rotate = 1'b1;
      end
      ST_DIVIDE: begin
        div_step = ~(last_div & out_valid_q & ~out_if.ready);
        out_load = last_div & div_step;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // state and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      primed_q <= 1'b0;
      step_q   <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        primed_q <= 1'b1;
      end
      if (accept || keep_en || ((cmp_en || acc_en) && last_bit)) begin
        step_q <= '0;
      end else if (cmp_en || acc_en || div_step) begin
        step_q <= step_q + step_t'(1);
      end
    end
  end

  // window shift line, rotated right one bit per serial cycle
  for (genvar i = 0; i < WINDOW; i++) begin : g_win
    assign lsb_w[i] = win_q[i][0];
    if (i == 0) begin : g_head
      always_ff @(posedge clk_i) begin
        if (accept) begin
          win_q[i] <= in_if.sample;
        end else if (rotate) begin
          win_q[i] <= {win_q[i][0], win_q[i][SAMPLE_BITS-1:1]};
        end
      end
    end else begin : g_tail
      always_ff @(posedge clk_i) begin
        if (accept) begin
          win_q[i] <= primed_q ? win_q[i-1] : in_if.sample;
        end else if (rotate) begin
          win_q[i] <= {win_q[i][0], win_q[i][SAMPLE_BITS-1:1]};
        end
      end
    end
  end

  // pairwise greater-than flags, built LSB first
  for (genvar i = 0; i < WINDOW; i++) begin : g_row
    for (genvar j = i + 1; j < WINDOW; j++) begin : g_col
      always_ff @(posedge clk_i) begin
        if (accept) begin
          gt_q[i][j] <= 1'b0;
        end else if (cmp_en) begin
          gt_q[i][j] <= (lsb_w[i] & ~lsb_w[j]) | (~(lsb_w[i] ^ lsb_w[j]) & gt_q[i][j]);
        end
      end
    end
  end

  // rank of each entry: smaller values, ties broken by position
  for (genvar i = 0; i < WINDOW; i++) begin : g_rank
    for (genvar j = 0; j < WINDOW; j++) begin : g_below
      if (j > i) begin : g_after
        assign below_w[i][j] = gt_q[i][j];
      end else if (j < i) begin : g_before
        assign below_w[i][j] = ~gt_q[j][i];
      end else begin : g_self
        assign below_w[i][j] = 1'b0;
      end
    end
    assign rank_w[i] = rank_t'($countones(below_w[i]));
    assign keep_w[i] = (rank_w[i] >= trim_w) && (cnt_t'(rank_w[i]) < hi_w);
  end

  always_ff @(posedge clk_i) begin
    if (keep_en) begin
      keep_q <= keep_w;
    end
  end

  // serial column sum of the kept entries
  assign col_w = col_t'($countones(keep_q & lsb_w)) + col_t'(carry_q);

  // restoring division step
  always_comb begin
    trial_w   = {rem_q, quo_q[SUM_BITS-1]};
    quo_bit_w = (trial_w >= {1'b0, cnt_w});
    rem_d     = quo_bit_w ? cnt_t'(trial_w - {1'b0, cnt_w}) : trial_w[CNT_BITS-1:0];
    quo_d     = {quo_q[SUM_BITS-2:0], quo_bit_w};
  end

  // sum and division registers
  always_ff @(posedge clk_i) begin
    if (keep_en) begin
      carry_q <= '0;
    end else if (acc_en) begin
      sum_lo_q <= {col_w[0], sum_lo_q[SAMPLE_BITS-1:1]};
      carry_q  <= col_w[RANK_BITS:1];
    end
    if (acc_en && last_bit) begin
      quo_q <= {col_w[RANK_BITS:1], col_w[0], sum_lo_q[SAMPLE_BITS-1:1]};
      rem_q <= '0;
    end else if (div_step) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_mean_q <= quo_d[OUT_BITS-1:0];
    end
  end

  assign in_if.ready         = in_ready;
  assign out_if.valid        = out_valid_q;
  assign out_if.trimmed_mean = out_mean_q;

endmodule

`default_nettype wire

FILE: hw/rtl/tmw_checker.sv
// port-level checks of the trimmed mean window filter, bound to the top level
`default_nettype none

module tmw_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_ready_i,
  input wire logic           out_valid_i,
  input wire logic           out_ready_i,
  input wire tmw_pkg::mean_t out_mean_i
);
  import tmw_pkg::*;

  // a result waiting on the output holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output item dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_mean_i))
    else $error("output item changed while stalled");

  // an accepted item keeps the input closed while it is worked on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken again while busy");

  // a new result appears only as the input reopens
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> in_ready_i)
    else $error("result produced without finishing the item");

endmodule

bind trimmed_mean_window_filter_top tmw_checker u_tmw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_mean_i  (out_if.trimmed_mean)
);

`default_nettype wire
